// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use expands to one labelled
// concurrent assertion on the rising clock edge, switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/w3sef_pkg.sv =====
package w3sef_pkg;

    // Frame size limits and the counter widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W     = $clog2(MAX_HEIGHT + 2);

    // Fixed field widths of the pixel data and the register file.
    localparam int CHAN_W     = 8;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int THRESH_W   = 8;
    localparam int WEIGHT_W   = 17;
    localparam int PROD_W     = WEIGHT_W + CHAN_W;
    localparam int GSUM_W     = PROD_W + 2;
    localparam int GRAY_FRAC  = 16;
    localparam int GSHIFT_W   = GSUM_W - GRAY_FRAC;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;

    // Register values after reset.
    localparam logic [CFG_WID_W-1:0] RST_WIDTH     = CFG_WID_W'(1024);
    localparam logic [CFG_HGT_W-1:0] RST_HEIGHT    = CFG_HGT_W'(1024);
    localparam logic [THRESH_W-1:0]  RST_THRESHOLD = THRESH_W'(128);
    localparam logic [WEIGHT_W-1:0]  RST_WEIGHT_R  = WEIGHT_W'(19595);
    localparam logic [WEIGHT_W-1:0]  RST_WEIGHT_G  = WEIGHT_W'(38470);
    localparam logic [WEIGHT_W-1:0]  RST_WEIGHT_B  = WEIGHT_W'(7471);

    typedef enum logic {
        MODE_SHARPEN = 1'b0,
        MODE_EDGE    = 1'b1
    } t_filter_mode;

    typedef enum logic [2:0] {
        REG_FILTER_MODE    = 3'd0,
        REG_IMAGE_WIDTH    = 3'd1,
        REG_IMAGE_HEIGHT   = 3'd2,
        REG_EDGE_THRESHOLD = 3'd3,
        REG_WEIGHT_RED     = 3'd4,
        REG_WEIGHT_GREEN   = 3'd5,
        REG_WEIGHT_BLUE    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic              flush;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_end;
    } t_out_word;

endpackage

// ===== hw/rtl/window_3x3_sharpen_edge_filter.sv =====
// 3x3 sharpen / edge filter for a raster RGB pixel stream.
// Input channel: i_in_valid / o_in_stall carry one word per pixel in raster
// order; a word with flush set carries no pixel and only drains the last row
// once every pixel of the frame has arrived (earlier it is taken and dropped).
// Output channel: o_out_valid / i_out_stall carry one filtered pixel per word,
// frame_end marking the last pixel of the frame. Results trail the input by
// one row plus one pixel, so each frame needs width+1 drain words at its end.
// Throughput is one word per cycle while the receiver does not stall. After
// the word that completes its neighbourhood is taken, a result word passes
// line buffer read, window, gray products, gray sum and threshold in turn.
// The two line buffers are single-write memories of MAX_WIDTH pixels; the
// top row read comes from a bypass register when the row is one pixel wide.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// then raises o_in_stall. Reset clears the counters, the pipeline and the
// registers to their defaults; no memory clearing pass is needed. Writing
// the width or the height restarts the frame. The APB port is always ready.
module window_3x3_sharpen_edge_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  w3sef_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output w3sef_pkg::t_out_word                o_out_word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [w3sef_pkg::ADDR_W-1:0]        paddr,
    input  logic [w3sef_pkg::DATA_W-1:0]        pwdata,
    output logic [w3sef_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    `include "assert_macros.svh"

    localparam int CW  = w3sef_pkg::COL_W;
    localparam int WW  = w3sef_pkg::WID_W;
    localparam int HW  = w3sef_pkg::HGT_W;
    localparam int IRW = w3sef_pkg::IROW_W;
    localparam int PW  = w3sef_pkg::PROD_W;
    localparam int GW  = w3sef_pkg::GSUM_W;
    localparam int SW  = w3sef_pkg::GSHIFT_W;

    // Register file.
    w3sef_pkg::t_filter_mode                 r_cfg_mode;
    logic [w3sef_pkg::CFG_WID_W-1:0]         r_cfg_width;
    logic [w3sef_pkg::CFG_HGT_W-1:0]         r_cfg_height;
    logic [w3sef_pkg::THRESH_W-1:0]          r_cfg_thresh;
    logic [w3sef_pkg::WEIGHT_W-1:0]          r_cfg_wt [3];

    w3sef_pkg::t_reg_idx cfg_idx;
    logic                cfg_wr;
    logic                size_wr;
    logic [WW-1:0]       eff_w;
    logic [HW-1:0]       eff_h;

    // Input side counters and line buffers.
    logic [CW-1:0]       r_in_col;
    logic [IRW-1:0]      r_in_row;
    logic [CW-1:0]       n_in_col;
    logic [IRW-1:0]      n_in_row;
    w3sef_pkg::t_pixel   r_above_mem [w3sef_pkg::MAX_WIDTH];
    w3sef_pkg::t_pixel   r_mid_mem [w3sef_pkg::MAX_WIDTH];
    w3sef_pkg::t_pixel   r_above_raw;
    w3sef_pkg::t_pixel   r_mid_raw;
    w3sef_pkg::t_pixel   in_pix;
    logic                in_acc;
    logic                drain;
    logic                flush_skip;
    logic                live;
    logic                in_emit;
    logic                in_last_col;
    logic                in_frame_done;

    // First stage: line buffer read data and pixel of the word taken.
    logic                r_s1_v;
    logic [CW-1:0]       r_s1_idx;
    w3sef_pkg::t_pixel   r_s1_pix;
    logic                r_s1_above_ok;
    logic                r_s1_mid_ok;
    logic                r_s1_emit;
    logic                r_byp_sel;
    w3sef_pkg::t_pixel   r_byp_pix;
    w3sef_pkg::t_pixel   s1_above;
    w3sef_pkg::t_pixel   s1_mid;
    logic                s1_move;

    // Window and output side counters.
    w3sef_pkg::t_pixel   r_win [3][3];
    logic [CW-1:0]       r_out_col;
    logic [HW-1:0]       r_out_row;
    logic                out_top;
    logic                out_bottom;
    logic                out_left;
    logic                out_right;
    logic                out_last;
    w3sef_pkg::t_pixel   nb [5];

    // Later stages: neighbourhood, products, gray values.
    logic                r_s2_v;
    w3sef_pkg::t_pixel   r_s2_nb [5];
    logic                r_s2_fe;
    logic                r_s3_v;
    logic [PW-1:0]       r_s3_prod [5][3];
    w3sef_pkg::t_pixel   r_s3_sharp;
    logic                r_s3_fe;
    logic                r_s4_v;
    logic [w3sef_pkg::CHAN_W-1:0] r_s4_gray [5];
    w3sef_pkg::t_pixel   r_s4_sharp;
    logic                r_s4_fe;
    logic                r_out_v;
    w3sef_pkg::t_out_word r_out_word;

    logic                take_out;
    logic                take4;
    logic                take3;
    logic                take2;
    logic                take1;

    // One sharpened channel: five times the centre less the four neighbours.
    function automatic logic [7:0] sharp_chan(input logic [7:0] c, input logic [7:0] u,
                                              input logic [7:0] d, input logic [7:0] l,
                                              input logic [7:0] r);
        logic [10:0]        five_c;
        logic [9:0]         nsum;
        logic signed [12:0] diff;
        logic [7:0]         res;
        five_c = 11'({c, 2'b00}) + 11'(c);
        nsum   = 10'(u) + 10'(d) + 10'(l) + 10'(r);
        diff   = $signed({2'b00, five_c}) - $signed({3'b000, nsum});
        if (diff < 0) begin
            res = 8'd0;
        end else if (diff > 13'sd255) begin
            res = 8'hFF;
        end else begin
            res = diff[7:0];
        end
        return res;
    endfunction

    // Gray value of one pixel from its three weighted products.
    function automatic logic [7:0] gray_of(input logic [PW-1:0] pr, input logic [PW-1:0] pg,
                                           input logic [PW-1:0] pb);
        logic [GW-1:0] sum;
        logic [SW-1:0] sh;
        logic [7:0]    res;
        sum = GW'(pr) + GW'(pg) + GW'(pb);
        sh  = sum[GW-1:w3sef_pkg::GRAY_FRAC];
        if (sh > SW'(255)) begin
            res = 8'hFF;
        end else begin
            res = sh[7:0];
        end
        return res;
    endfunction

    // Configuration port decode.
    assign cfg_idx = w3sef_pkg::t_reg_idx'(paddr[w3sef_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign size_wr = cfg_wr && (cfg_idx == w3sef_pkg::REG_IMAGE_WIDTH ||
                                cfg_idx == w3sef_pkg::REG_IMAGE_HEIGHT);
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= w3sef_pkg::MODE_SHARPEN;
            r_cfg_width  <= w3sef_pkg::RST_WIDTH;
            r_cfg_height <= w3sef_pkg::RST_HEIGHT;
            r_cfg_thresh <= w3sef_pkg::RST_THRESHOLD;
            r_cfg_wt[0]  <= w3sef_pkg::RST_WEIGHT_R;
            r_cfg_wt[1]  <= w3sef_pkg::RST_WEIGHT_G;
            r_cfg_wt[2]  <= w3sef_pkg::RST_WEIGHT_B;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                w3sef_pkg::REG_FILTER_MODE: begin
                    r_cfg_mode <= w3sef_pkg::t_filter_mode'(pwdata[0]);
                end
                w3sef_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_width <= pwdata[w3sef_pkg::CFG_WID_W-1:0];
                end
                w3sef_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_height <= pwdata[w3sef_pkg::CFG_HGT_W-1:0];
                end
                w3sef_pkg::REG_EDGE_THRESHOLD: begin
                    r_cfg_thresh <= pwdata[w3sef_pkg::THRESH_W-1:0];
                end
                w3sef_pkg::REG_WEIGHT_RED: begin
                    r_cfg_wt[0] <= pwdata[w3sef_pkg::WEIGHT_W-1:0];
                end
                w3sef_pkg::REG_WEIGHT_GREEN: begin
                    r_cfg_wt[1] <= pwdata[w3sef_pkg::WEIGHT_W-1:0];
                end
                w3sef_pkg::REG_WEIGHT_BLUE: begin
                    r_cfg_wt[2] <= pwdata[w3sef_pkg::WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (cfg_idx)
            w3sef_pkg::REG_FILTER_MODE:    prdata = w3sef_pkg::DATA_W'(r_cfg_mode);
            w3sef_pkg::REG_IMAGE_WIDTH:    prdata = w3sef_pkg::DATA_W'(r_cfg_width);
            w3sef_pkg::REG_IMAGE_HEIGHT:   prdata = w3sef_pkg::DATA_W'(r_cfg_height);
            w3sef_pkg::REG_EDGE_THRESHOLD: prdata = w3sef_pkg::DATA_W'(r_cfg_thresh);
            w3sef_pkg::REG_WEIGHT_RED:     prdata = w3sef_pkg::DATA_W'(r_cfg_wt[0]);
            w3sef_pkg::REG_WEIGHT_GREEN:   prdata = w3sef_pkg::DATA_W'(r_cfg_wt[1]);
            w3sef_pkg::REG_WEIGHT_BLUE:    prdata = w3sef_pkg::DATA_W'(r_cfg_wt[2]);
            default:                       prdata = '0;
        endcase
    end

    // Frame size in use, clamped to the supported range.
    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_width) > w3sef_pkg::MAX_WIDTH) begin
            eff_w = WW'(w3sef_pkg::MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_height) > w3sef_pkg::MAX_HEIGHT) begin
            eff_h = HW'(w3sef_pkg::MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_height);
        end
    end

    // Pipeline flow: a stage loads when it is empty or its word moves on.
    assign take_out   = !r_out_v || !i_out_stall;
    assign take4      = !r_s4_v || take_out;
    assign take3      = !r_s3_v || take4;
    assign take2      = !r_s2_v || take3;
    assign take1      = !r_s1_v || take2;
    assign o_in_stall = !take1;
    assign s1_move    = r_s1_v && take2;

    // Input word classification. Once all pixels have arrived every word drains.
    assign in_acc        = i_in_valid && take1;
    assign drain         = r_in_row >= IRW'(eff_h);
    assign flush_skip    = in_acc && i_in_word.flush && !drain;
    assign live          = in_acc && !flush_skip;
    assign in_emit       = (r_in_row >= IRW'(2)) || (r_in_row == IRW'(1) && r_in_col != '0);
    assign in_last_col   = (WW'(r_in_col) + WW'(1)) >= eff_w;
    assign in_frame_done = (r_in_row == IRW'(eff_h) + IRW'(1)) && (r_in_col == '0);

    always_comb begin
        if (drain) begin
            in_pix = '0;
        end else begin
            in_pix = '{red: i_in_word.in_red, green: i_in_word.in_green,
                       blue: i_in_word.in_blue};
        end
    end

    // Next input position; the word that emits the frame's last pixel restarts it.
    always_comb begin
        if (in_frame_done) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (in_last_col) begin
            n_in_col = '0;
            n_in_row = r_in_row + IRW'(1);
        end else begin
            n_in_col = r_in_col + CW'(1);
            n_in_row = r_in_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (size_wr) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (live) begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    // Middle row buffer: read the previous row, then store the new pixel.
    always_ff @(posedge i_clk) begin
        if (live) begin
            r_mid_raw <= r_mid_mem[r_in_col];
            r_mid_mem[r_in_col] <= in_pix;
        end
    end

    // Top row buffer: takes the middle row value once the word leaves stage one.
    always_ff @(posedge i_clk) begin
        if (live) begin
            r_above_raw <= r_above_mem[r_in_col];
        end
        if (s1_move) begin
            r_above_mem[r_s1_idx] <= s1_mid;
        end
    end

    // Stage one control. The bypass covers a predecessor at the same column
    // whose top row write has not yet landed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (take1) begin
            r_s1_v <= live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (live) begin
            r_s1_idx      <= r_in_col;
            r_s1_pix      <= in_pix;
            r_s1_above_ok <= r_in_row >= IRW'(2);
            r_s1_mid_ok   <= r_in_row >= IRW'(1);
            r_s1_emit     <= in_emit;
            r_byp_sel     <= r_s1_v && (r_s1_idx == r_in_col);
            r_byp_pix     <= s1_mid;
        end
    end

    assign s1_mid   = r_s1_mid_ok ? r_mid_raw : '0;
    assign s1_above = !r_s1_above_ok ? '0 : (r_byp_sel ? r_byp_pix : r_above_raw);

    // Window shift: the oldest column drops out, the new column enters.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= s1_above;
            r_win[1][2] <= s1_mid;
            r_win[2][2] <= r_s1_pix;
        end
    end

    // Border handling: neighbours outside the frame take the centre value.
    assign out_top    = r_out_row == '0;
    assign out_bottom = (r_out_row + HW'(1)) >= eff_h;
    assign out_left   = r_out_col == '0;
    assign out_right  = (WW'(r_out_col) + WW'(1)) >= eff_w;
    assign out_last   = out_bottom && out_right;

    always_comb begin
        nb[0] = r_win[1][2];
        nb[1] = out_top    ? r_win[1][2] : r_win[0][2];
        nb[2] = out_bottom ? r_win[1][2] : r_win[2][2];
        nb[3] = out_left   ? r_win[1][2] : r_win[1][1];
        nb[4] = out_right  ? r_win[1][2] : s1_mid;
    end

    // Output position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (size_wr) begin
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s1_move && r_s1_emit) begin
            if (out_last) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (out_right) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + HW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    // Stage two: the five pixels of the neighbourhood.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (take2) begin
            r_s2_v <= r_s1_v && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_emit) begin
            r_s2_nb <= nb;
            r_s2_fe <= out_last;
        end
    end

    // Stage three: gray products of every pixel of the neighbourhood and the sharpened pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (take3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && take3) begin
            for (int p = 0; p < 5; p++) begin
                r_s3_prod[p][0] <= PW'(r_cfg_wt[0]) * PW'(r_s2_nb[p].red);
                r_s3_prod[p][1] <= PW'(r_cfg_wt[1]) * PW'(r_s2_nb[p].green);
                r_s3_prod[p][2] <= PW'(r_cfg_wt[2]) * PW'(r_s2_nb[p].blue);
            end
            r_s3_sharp.red   <= sharp_chan(r_s2_nb[0].red, r_s2_nb[1].red, r_s2_nb[2].red,
                                           r_s2_nb[3].red, r_s2_nb[4].red);
            r_s3_sharp.green <= sharp_chan(r_s2_nb[0].green, r_s2_nb[1].green,
                                           r_s2_nb[2].green, r_s2_nb[3].green,
                                           r_s2_nb[4].green);
            r_s3_sharp.blue  <= sharp_chan(r_s2_nb[0].blue, r_s2_nb[1].blue, r_s2_nb[2].blue,
                                           r_s2_nb[3].blue, r_s2_nb[4].blue);
            r_s3_fe          <= r_s2_fe;
        end
    end

    // Stage four: gray value of each pixel of the neighbourhood, truncated and saturated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (take4) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_v && take4) begin
            for (int p = 0; p < 5; p++) begin
                r_s4_gray[p] <= gray_of(r_s3_prod[p][0], r_s3_prod[p][1], r_s3_prod[p][2]);
            end
            r_s4_sharp <= r_s3_sharp;
            r_s4_fe    <= r_s3_fe;
        end
    end

    // Output register: Laplacian threshold in edge mode, else the sharpened pixel.
    logic [9:0]         lap_c4;
    logic [9:0]         lap_nsum;
    logic signed [11:0] lap;
    logic               is_edge;
    w3sef_pkg::t_out_word n_out_word;

    always_comb begin
        lap_c4   = {r_s4_gray[0], 2'b00};
        lap_nsum = 10'(r_s4_gray[1]) + 10'(r_s4_gray[2]) + 10'(r_s4_gray[3]) +
                   10'(r_s4_gray[4]);
        lap      = $signed({2'b00, lap_c4}) - $signed({2'b00, lap_nsum});
        is_edge  = lap > $signed({4'b0000, r_cfg_thresh});
        if (r_cfg_mode == w3sef_pkg::MODE_EDGE) begin
            n_out_word.out_red   = is_edge ? 8'hFF : 8'h00;
            n_out_word.out_green = is_edge ? 8'hFF : 8'h00;
            n_out_word.out_blue  = is_edge ? 8'hFF : 8'h00;
        end else begin
            n_out_word.out_red   = r_s4_sharp.red;
            n_out_word.out_green = r_s4_sharp.green;
            n_out_word.out_blue  = r_s4_sharp.blue;
        end
        n_out_word.frame_end = r_s4_fe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (take_out) begin
            r_out_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_v && take_out) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out_word;

    // A word that emits nothing leaves no entry behind in stage two.
    `ASSERT_NEXT(a_no_emit_no_s2, s1_move && !r_s1_emit, !r_s2_v, "Stage two loaded a non-emitting word")
    // The last pixel of a frame returns the output position to the origin.
    `ASSERT_NEXT(a_frame_end_clears, s1_move && r_s1_emit && out_last, r_out_col == '0 && r_out_row == '0, "Output position not cleared after frame end")
    // A flush inside the frame leaves the input position untouched.
    `ASSERT_NEXT(a_flush_holds, flush_skip && !cfg_wr, $stable(r_in_col) && $stable(r_in_row), "Ignored flush moved the input position")
    // Input stall only when every stage holds a word.
    `ASSERT_SAME(a_stall_full, o_in_stall, r_s1_v && r_s2_v && r_s3_v && r_s4_v && r_out_v, "Input stalled with an empty stage")
    // A finished word in stage four reaches the output when it is free.
    `ASSERT_NEXT(a_s4_to_out, r_s4_v && take_out, r_out_v, "Stage four word lost on the way out")

endmodule
